### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sniffer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Assertion failed.");

// Next-cycle implication, disabled while reset is asserted.
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Assertion failed.");

`endif

### rtl/core/cfs_pkg.sv
// ---------------------------------------------------------------------------
// cfs_pkg
// Types, pattern tables and helpers for the content format sniffer.
// ---------------------------------------------------------------------------
package cfs_pkg;

    localparam int WIN  = 12;
    localparam int NSUB = 21;
    localparam int NPFX = 4;
    localparam int NANC = 3;
    localparam int PFX_MAXLEN = 5;
    localparam int ANC_MAXLEN = 9;

    // Substring pattern indexes.
    localparam int SUB_PLY_HDR_CLOSE = 0;
    localparam int SUB_FACET        = 1;
    localparam int SUB_OPENAPI_Q    = 2;
    localparam int SUB_OPENAPI_C    = 3;
    localparam int SUB_SWAGGER_Q    = 4;
    localparam int SUB_SWAGGER_C    = 5;
    localparam int SUB_STARTUML     = 6;
    localparam int SUB_INHERIT      = 7;
    localparam int SUB_GRAPHML      = 8;
    localparam int SUB_CREATE_TABLE = 9;
    localparam int SUB_SYNTAX       = 10;
    localparam int SUB_MESSAGE      = 11;
    localparam int SUB_BRACE        = 12;
    localparam int SUB_SCALAR       = 13;
    localparam int SUB_TYPE_QUERY   = 14;
    localparam int SUB_SCHEMA       = 15;
    localparam int SUB_ARROW_LONG   = 16;
    localparam int SUB_ARROW_DOT    = 17;
    localparam int SUB_ARROW_THICK  = 18;
    localparam int SUB_DIGRAPH      = 19;
    localparam int SUB_ARROW        = 20;

    // Prefix indexes.
    localparam int PFX_PDF   = 0;
    localparam int PFX_VOX   = 1;
    localparam int PFX_PLY   = 2;
    localparam int PFX_SOLID = 3;

    // Lead-anchored pattern indexes; the direction flag sits after them.
    localparam int ANC_DASH  = 0;
    localparam int ANC_FLOW  = 1;
    localparam int ANC_GRAPH = 2;
    localparam int ANC_DIR   = 3;

    // Patterns are right-aligned: the last character sits in bits [7:0].
    localparam logic [8*WIN-1:0] SUB_TEXT [NSUB] = '{
        "end\137header", "facet", "\"openapi\"", "openapi:",
        "\"swagger\"", "swagger:", "@startuml", "<|--",
        "<graphml", "create table", "syntax =", "message ",
        "{", "scalar ", "type Query", "schema {",
        "-->", "-.->", "==>", "digraph", "->"
    };

    localparam logic [3:0] SUB_LEN [NSUB] = '{
        4'd10, 4'd5, 4'd9, 4'd8, 4'd9, 4'd8, 4'd9, 4'd4,
        4'd8, 4'd12, 4'd8, 4'd8, 4'd1, 4'd7, 4'd10, 4'd8,
        4'd3, 4'd4, 4'd3, 4'd7, 4'd2
    };

    localparam logic [7:0] PFX_CHR [NPFX][PFX_MAXLEN] = '{
        '{"%", "P", "D", "F", "-"},
        '{"V", "O", "X", " ", 8'h00},
        '{"p", "l", "y", 8'h00, 8'h00},
        '{"s", "o", "l", "i", "d"}
    };

    localparam logic [2:0] PFX_LEN [NPFX] = '{3'd5, 3'd4, 3'd3, 3'd5};

    localparam logic [7:0] ANC_CHR [NANC][ANC_MAXLEN] = '{
        '{"-", "-", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "l", "o", "w", "c", "h", "a", "r", "t"},
        '{"g", "r", "a", "p", "h", " ", 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] ANC_LEN [NANC] = '{4'd3, 4'd9, 4'd6};

    // Offset from the lead byte at which the second direction letter arrives.
    localparam logic [3:0] DIR_OFFSET = 4'd7;

    typedef enum logic [3:0] {
        FMT_UNKNOWN  = 4'd0,
        FMT_PDF      = 4'd1,
        FMT_VOX      = 4'd2,
        FMT_PLY      = 4'd3,
        FMT_STL      = 4'd4,
        FMT_OPENAPI  = 4'd5,
        FMT_JSON     = 4'd6,
        FMT_PLANTUML = 4'd7,
        FMT_GRAPHML  = 4'd8,
        FMT_XML      = 4'd9,
        FMT_YAML     = 4'd10,
        FMT_SQL      = 4'd11,
        FMT_PROTOBUF = 4'd12,
        FMT_GRAPHQL  = 4'd13,
        FMT_MERMAID  = 4'd14,
        FMT_DOT      = 4'd15
    } t_format_code;

    typedef struct packed {
        logic [WIN-1:0][7:0] recent;
        logic [2:0]          byte_pos;
        logic [NPFX-1:0]     prefix_flags;
        logic                glyph_seen;
        logic [7:0]          lead_char;
        logic [3:0]          lead_offset;
        logic [NANC:0]       lead_flags;
        logic [NSUB-1:0]     sub_flags;
    } t_sniff_state;

    function automatic logic [7:0] fold_upper(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

endpackage

### rtl/core/cfs_track.sv
// ---------------------------------------------------------------------------
// cfs_track
// Sniffer state: byte window, sticky pattern flags and anchored matches.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cfs_track import cfs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [7:0]   i_byte,
    input  logic         i_has,
    input  logic         i_last,
    output t_sniff_state o_next
);

    t_sniff_state r_state;
    t_sniff_state n_state;

    always_comb begin
        logic [7:0] nb [WIN];
        logic [7:0] w;
        logic [7:0] pc;
        logic [7:0] ac;
        logic [3:0] k;
        logic       hit;
        logic       first;
        n_state = r_state;
        for (int j = 0; j < WIN; j++) begin
            nb[j] = 8'h00;
        end
        w     = 8'h00;
        pc    = 8'h00;
        ac    = 8'h00;
        k     = 4'd0;
        hit   = 1'b0;
        first = 1'b0;
        if (i_en && i_has) begin
            n_state.recent = {i_byte, r_state.recent[WIN-1:1]};
            for (int j = 0; j < WIN; j++) begin
                nb[j] = n_state.recent[WIN-1-j];
            end
            for (int p = 0; p < NSUB; p++) begin
                hit = 1'b1;
                for (int j = 0; j < WIN; j++) begin
                    if (4'(j) < SUB_LEN[p]) begin
                        w = (p == SUB_CREATE_TABLE) ? fold_upper(nb[j]) : nb[j];
                        if (w != SUB_TEXT[p][8*j +: 8]) begin
                            hit = 1'b0;
                        end
                    end
                end
                if (hit) begin
                    n_state.sub_flags[p] = 1'b1;
                end
            end
            for (int p = 0; p < NPFX; p++) begin
                pc = (r_state.byte_pos < 3'(PFX_MAXLEN)) ? PFX_CHR[p][r_state.byte_pos] : 8'h00;
                if (r_state.byte_pos < PFX_LEN[p] && i_byte != pc) begin
                    n_state.prefix_flags[p] = 1'b1;
                end
            end
            if (r_state.byte_pos != 3'd7) begin
                n_state.byte_pos = r_state.byte_pos + 3'd1;
            end
            first = !r_state.glyph_seen && !is_blank(i_byte);
            if (first) begin
                n_state.glyph_seen = 1'b1;
                n_state.lead_char  = i_byte;
            end
            k = first ? 4'd0 : r_state.lead_offset;
            if (r_state.glyph_seen || first) begin
                for (int a = 0; a < NANC; a++) begin
                    ac = (k < 4'(ANC_MAXLEN)) ? ANC_CHR[a][k] : 8'h00;
                    if (k < ANC_LEN[a] && i_byte != ac) begin
                        n_state.lead_flags[a] = 1'b1;
                    end
                end
                if (k == DIR_OFFSET) begin
                    if ((r_state.recent[WIN-1] == "T" && (i_byte == "D" || i_byte == "B")) ||
                        (r_state.recent[WIN-1] == "L" && i_byte == "R") ||
                        (r_state.recent[WIN-1] == "R" && i_byte == "L") ||
                        (r_state.recent[WIN-1] == "B" && i_byte == "T")) begin
                        n_state.lead_flags[ANC_DIR] = 1'b1;
                    end
                end
                n_state.lead_offset = (k != 4'd15) ? k + 4'd1 : k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en && i_last) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_next = n_state;

    `CFS_ASSERT_NEXT(a_clear_after_last, i_clk, i_rst_n, i_en && i_last, r_state.byte_pos == 3'd0 && !r_state.glyph_seen)
    `CFS_ASSERT_IMPLY(a_no_lead_without_glyph, i_clk, i_rst_n, !r_state.glyph_seen, r_state.lead_offset == 4'd0 && r_state.lead_char == 8'h00 && r_state.lead_flags == '0)
    `CFS_ASSERT_IMPLY(a_no_flags_without_bytes, i_clk, i_rst_n, r_state.byte_pos == 3'd0, r_state.sub_flags == '0 && r_state.prefix_flags == '0)

endmodule

### rtl/core/cfs_classify.sv
// ---------------------------------------------------------------------------
// cfs_classify
// Priority selection of the format code from the sniffer state.
// ---------------------------------------------------------------------------
module cfs_classify import cfs_pkg::*; (
    input  t_sniff_state i_state,
    output t_format_code o_code
);

    logic [NPFX-1:0] w_pfx_ok;
    logic [NANC-1:0] w_anc_ok;
    logic [NSUB-1:0] w_sub;

    assign w_sub = i_state.sub_flags;

    always_comb begin
        for (int p = 0; p < NPFX; p++) begin
            w_pfx_ok[p] = !i_state.prefix_flags[p] && i_state.byte_pos >= PFX_LEN[p];
        end
        for (int a = 0; a < NANC; a++) begin
            w_anc_ok[a] = !i_state.lead_flags[a] && i_state.lead_offset >= ANC_LEN[a];
        end
    end

    always_comb begin
        if (i_state.byte_pos == 3'd0) begin
            o_code = FMT_UNKNOWN;
        end else if (w_pfx_ok[PFX_PDF]) begin
            o_code = FMT_PDF;
        end else if (w_pfx_ok[PFX_VOX]) begin
            o_code = FMT_VOX;
        end else if (w_pfx_ok[PFX_PLY] && w_sub[SUB_PLY_HDR_CLOSE]) begin
            o_code = FMT_PLY;
        end else if (w_pfx_ok[PFX_SOLID] && w_sub[SUB_FACET]) begin
            o_code = FMT_STL;
        end else if (!i_state.glyph_seen) begin
            o_code = FMT_UNKNOWN;
        end else if (w_sub[SUB_OPENAPI_Q] || w_sub[SUB_OPENAPI_C] ||
                     w_sub[SUB_SWAGGER_Q] || w_sub[SUB_SWAGGER_C]) begin
            o_code = FMT_OPENAPI;
        end else if (i_state.lead_char == "{" || i_state.lead_char == "[") begin
            o_code = FMT_JSON;
        end else if (w_sub[SUB_STARTUML] || w_sub[SUB_INHERIT]) begin
            o_code = FMT_PLANTUML;
        end else if (w_sub[SUB_GRAPHML]) begin
            o_code = FMT_GRAPHML;
        end else if (i_state.lead_char == "<") begin
            o_code = FMT_XML;
        end else if (w_anc_ok[ANC_DASH]) begin
            o_code = FMT_YAML;
        end else if (w_sub[SUB_CREATE_TABLE]) begin
            o_code = FMT_SQL;
        end else if (w_sub[SUB_SYNTAX] || (w_sub[SUB_MESSAGE] && w_sub[SUB_BRACE])) begin
            o_code = FMT_PROTOBUF;
        end else if (w_sub[SUB_SCALAR] || w_sub[SUB_TYPE_QUERY] || w_sub[SUB_SCHEMA]) begin
            o_code = FMT_GRAPHQL;
        end else if (w_anc_ok[ANC_FLOW] ||
                     (w_anc_ok[ANC_GRAPH] && i_state.lead_flags[ANC_DIR]) ||
                     w_sub[SUB_ARROW_LONG] || w_sub[SUB_ARROW_DOT] ||
                     w_sub[SUB_ARROW_THICK]) begin
            o_code = FMT_MERMAID;
        end else if (w_sub[SUB_DIGRAPH] || w_sub[SUB_ARROW] || w_anc_ok[ANC_GRAPH]) begin
            o_code = FMT_DOT;
        end else begin
            o_code = FMT_UNKNOWN;
        end
    end

endmodule

### rtl/core/content_format_sniffer_unit.sv
// Throughput: one request per cycle while not stalled on a pending last request;
// the input register is followed by one pass of pattern compares and priority
// logic into the result register. A pending last request waits only while the
// result register is full and stalled. Reset is synchronous and active low; it
// clears the window, all flags and both valid bits. State also returns to reset
// after every request marked last.
// ---------------------------------------------------------------------------
// content_format_sniffer_unit
// Streams content bytes and reports a format code at the end of each content.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module content_format_sniffer_unit import cfs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_has_byte,
    input  logic       i_is_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_format_code
);

    logic         r_in_valid;
    logic [7:0]   r_data_byte;
    logic         r_has_byte;
    logic         r_is_last;
    logic         r_out_valid;
    t_format_code r_code;

    logic         w_out_free;
    logic         w_proc;
    logic         w_fire_last;
    t_sniff_state w_next;
    t_format_code w_code;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_proc      = r_in_valid && (!r_is_last || w_out_free);
    assign w_fire_last = r_in_valid && r_is_last && w_out_free;
    assign o_in_stall  = r_in_valid && !w_proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_data_byte <= i_data_byte;
            r_has_byte  <= i_has_byte;
            r_is_last   <= i_is_last;
        end
    end

    cfs_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_proc),
        .i_byte  (r_data_byte),
        .i_has   (r_has_byte),
        .i_last  (r_is_last),
        .o_next  (w_next)
    );

    cfs_classify u_classify (
        .i_state (w_next),
        .o_code  (w_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire_last) begin
            r_code <= w_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_format_code = r_code;

    `CFS_ASSERT_IMPLY(a_result_from_last, i_clk, i_rst_n, $rose(r_out_valid), $past(w_fire_last))
    `CFS_ASSERT_IMPLY(a_stall_only_on_last, i_clk, i_rst_n, o_in_stall, r_in_valid && r_is_last && r_out_valid)
    `CFS_ASSERT_NEXT(a_fire_sets_valid, i_clk, i_rst_n, w_fire_last, r_out_valid)

endmodule
